@@ rtl/lwe_pkg.sv @@
// Package for the link watchdog escalation block: action and mode codes,
// register indexes and reset values of the configuration registers.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package lwe_pkg;

    // Widths fixed by the word format and the register file.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned MS_W        = 32;

    // Defaults for the top-level parameters.
    localparam logic [MS_W-1:0] BOOT_ANNOUNCE_DELAY_MS_DEF = 32'd10000;
    localparam int unsigned     TIME_WIDTH_DEF             = 32;

    // Actions ordered by one event.
    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_PROBE  = 3'd1,
        ACT_SOFT   = 3'd2,
        ACT_HARD   = 3'd3,
        ACT_REBOOT = 3'd4
    } action_t;

    // Escalation tier.
    typedef enum logic [1:0] {
        MODE_HEALTHY = 2'd0,
        MODE_SOFT    = 2'd1,
        MODE_HARD    = 2'd2,
        MODE_REBOOT  = 2'd3
    } wd_mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SOFT_RETRY_LIMIT     = 3'd0,
        REG_HARD_RETRY_LIMIT     = 3'd1,
        REG_PROBE_FAIL_THRESHOLD = 3'd2,
        REG_HEALTHY_INTERVAL_MS  = 3'd3,
        REG_RECOVERY_INTERVAL_MS = 3'd4,
        REG_PROBE_TIMEOUT_MS     = 3'd5,
        REG_ANNOUNCE_REFRESH_MS  = 3'd6,
        REG_AUTO_REBOOT_ENABLE   = 3'd7
    } cfg_reg_t;

    // Reset values of the configuration registers.
    localparam logic [COUNT_W-1:0] SOFT_RETRY_LIMIT_RST     = 8'd3;
    localparam logic [COUNT_W-1:0] HARD_RETRY_LIMIT_RST     = 8'd2;
    localparam logic [COUNT_W-1:0] PROBE_FAIL_THRESHOLD_RST = 8'd3;
    localparam logic [MS_W-1:0]    HEALTHY_INTERVAL_MS_RST  = 32'd10000;
    localparam logic [MS_W-1:0]    RECOVERY_INTERVAL_MS_RST = 32'd5000;
    localparam logic [MS_W-1:0]    PROBE_TIMEOUT_MS_RST     = 32'd3000;
    localparam logic [MS_W-1:0]    ANNOUNCE_REFRESH_MS_RST  = 32'd60000;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

endpackage

@@ rtl/lwe_if.sv @@
// Valid/ready channel interfaces for the link watchdog escalation block:
// one for event words in, one for result words out.
// Depends on lwe_pkg for the field types.
`timescale 1ns / 1ps

interface lwe_in_if;
    import lwe_pkg::*;

    logic            valid;
    logic            ready;
    logic [MS_W-1:0] now_ms;
    logic            link_up;
    logic            probe_reply;
    logic            probe_can_start;
    logic            hard_reconnect_ok;

    modport source (
        output valid, now_ms, link_up, probe_reply, probe_can_start, hard_reconnect_ok,
        input  ready
    );
    modport sink (
        input  valid, now_ms, link_up, probe_reply, probe_can_start, hard_reconnect_ok,
        output ready
    );
endinterface

interface lwe_out_if;
    import lwe_pkg::*;

    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic               end_probe;
    logic               restart_announce;
    logic               resync_time;
    logic [1:0]         watchdog_state;
    logic [COUNT_W-1:0] soft_tries;
    logic [COUNT_W-1:0] hard_tries;
    logic [COUNT_W-1:0] probe_fails;

    modport source (
        output valid, action, end_probe, restart_announce, resync_time,
               watchdog_state, soft_tries, hard_tries, probe_fails,
        input  ready
    );
    modport sink (
        input  valid, action, end_probe, restart_announce, resync_time,
               watchdog_state, soft_tries, hard_tries, probe_fails,
        output ready
    );
endinterface

@@ rtl/link_watchdog_escalation_top.sv @@
// Top level of the link watchdog escalation block: input register,
// single-pass decision logic, watchdog state and result register.
// Depends on lwe_pkg and on the channel interfaces in lwe_if.sv.
//
//   Channel   Direction  Handshake     Carries
//   evt       in         valid/ready   now_ms, link_up, probe_reply,
//                                      probe_can_start, hard_reconnect_ok
//   res       out        valid/ready   action, end_probe, restart_announce,
//                                      resync_time, watchdog_state, tries
//   cfg       in         cfg_wr_en     cfg_index, cfg_data (write only)
//
// Every event word gives exactly one result word. A word waits in the input
// register, where the decision logic evaluates it against the watchdog
// state; at the edge it moves to the result register the state is updated,
// so the next word already sees it. Result valid rises at that same edge.
// One word is taken per clock as long as the result side keeps taking
// words. The result register and the input register each hold one word, so
// a stalled sink fills both and only then drops evt.ready. Reset clears the
// handshake and restores all watchdog state and configuration registers to
// their defaults.
`timescale 1ns / 1ps

module link_watchdog_escalation_top
    import lwe_pkg::*;
#(
    parameter logic [MS_W-1:0] BOOT_ANNOUNCE_DELAY_MS = BOOT_ANNOUNCE_DELAY_MS_DEF,
    parameter int unsigned     TIME_WIDTH             = TIME_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    lwe_in_if.sink                 evt,
    lwe_out_if.source              res
);

    // Time compares run in a width that holds both the stored time and the
    // 32-bit intervals.
    localparam int unsigned TW = TIME_WIDTH;
    localparam int unsigned CW = (TW > MS_W) ? TW : MS_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] soft_limit_reg;
    logic [COUNT_W-1:0] hard_limit_reg;
    logic [COUNT_W-1:0] fail_thresh_reg;
    logic [MS_W-1:0]    healthy_ivl_reg;
    logic [MS_W-1:0]    recovery_ivl_reg;
    logic [MS_W-1:0]    probe_tmo_reg;
    logic [MS_W-1:0]    ann_refresh_reg;
    logic               auto_reboot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            soft_limit_reg   <= SOFT_RETRY_LIMIT_RST;
            hard_limit_reg   <= HARD_RETRY_LIMIT_RST;
            fail_thresh_reg  <= PROBE_FAIL_THRESHOLD_RST;
            healthy_ivl_reg  <= HEALTHY_INTERVAL_MS_RST;
            recovery_ivl_reg <= RECOVERY_INTERVAL_MS_RST;
            probe_tmo_reg    <= PROBE_TIMEOUT_MS_RST;
            ann_refresh_reg  <= ANNOUNCE_REFRESH_MS_RST;
            auto_reboot_reg  <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SOFT_RETRY_LIMIT:     soft_limit_reg   <= cfg_data[COUNT_W-1:0];
                REG_HARD_RETRY_LIMIT:     hard_limit_reg   <= cfg_data[COUNT_W-1:0];
                REG_PROBE_FAIL_THRESHOLD: fail_thresh_reg  <= cfg_data[COUNT_W-1:0];
                REG_HEALTHY_INTERVAL_MS:  healthy_ivl_reg  <= cfg_data[MS_W-1:0];
                REG_RECOVERY_INTERVAL_MS: recovery_ivl_reg <= cfg_data[MS_W-1:0];
                REG_PROBE_TIMEOUT_MS:     probe_tmo_reg    <= cfg_data[MS_W-1:0];
                REG_ANNOUNCE_REFRESH_MS:  ann_refresh_reg  <= cfg_data[MS_W-1:0];
                REG_AUTO_REBOOT_ENABLE:   auto_reboot_reg  <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the result register. A word moves
    // forward when the result register is empty or being drained.
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;

    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign evt.ready = !in_valid_reg || advance;
    assign res.valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt.ready)
            begin
                in_valid_reg <= evt.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input payload register.
    logic [TW-1:0] now_reg;
    logic          link_up_reg;
    logic          reply_reg;
    logic          can_start_reg;
    logic          hard_ok_reg;

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            now_reg       <= TW'(evt.now_ms);
            link_up_reg   <= evt.link_up;
            reply_reg     <= evt.probe_reply;
            can_start_reg <= evt.probe_can_start;
            hard_ok_reg   <= evt.hard_reconnect_ok;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog state
    // ------------------------------------------------------------------
    wd_mode_t           mode_reg,       mode_next;
    logic [COUNT_W-1:0] soft_cnt_reg,   soft_cnt_next;
    logic [COUNT_W-1:0] hard_cnt_reg,   hard_cnt_next;
    logic [COUNT_W-1:0] fail_cnt_reg,   fail_cnt_next;
    logic               probe_run_reg,  probe_run_next;
    logic [TW-1:0]      probe_t0_reg,   probe_t0_next;
    logic [TW-1:0]      last_check_reg, last_check_next;
    logic [TW-1:0]      last_ann_reg,   last_ann_next;
    logic               boot_done_reg,  boot_done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_HEALTHY;
            soft_cnt_reg   <= '0;
            hard_cnt_reg   <= '0;
            fail_cnt_reg   <= '0;
            probe_run_reg  <= 1'b0;
            probe_t0_reg   <= '0;
            last_check_reg <= '0;
            last_ann_reg   <= '0;
            boot_done_reg  <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg       <= mode_next;
            soft_cnt_reg   <= soft_cnt_next;
            hard_cnt_reg   <= hard_cnt_next;
            fail_cnt_reg   <= fail_cnt_next;
            probe_run_reg  <= probe_run_next;
            probe_t0_reg   <= probe_t0_next;
            last_check_reg <= last_check_next;
            last_ann_reg   <= last_ann_next;
            boot_done_reg  <= boot_done_next;
        end
    end

    // ------------------------------------------------------------------
    // Decision logic for the word in the input register.
    // ------------------------------------------------------------------
    action_t            act;
    logic               end_probe_c;
    logic               announce_c;
    logic               resync_c;
    logic               recover;
    logic               finished;
    logic               timed_out;
    logic               check_due;
    logic               refresh_due;
    logic [MS_W-1:0]    interval;
    logic [TW-1:0]      probe_age;
    logic [TW-1:0]      check_age;
    logic [TW-1:0]      ann_age;
    logic [COUNT_W-1:0] fail_bumped;
    logic               boot_fire;
    logic [TW-1:0]      last_ann_next_boot;

    // Time differences wrap in the stored time width.
    assign probe_age   = now_reg - probe_t0_reg;
    assign check_age   = now_reg - last_check_reg;
    assign fail_bumped = (fail_cnt_reg == COUNT_MAX) ? fail_cnt_reg : fail_cnt_reg + 1'b1;
    assign timed_out   = CW'(probe_age) >= CW'(probe_tmo_reg);
    assign interval    = (mode_reg != MODE_HEALTHY || fail_cnt_reg != '0)
                         ? recovery_ivl_reg : healthy_ivl_reg;
    assign check_due   = CW'(check_age) >= CW'(interval);

    assign boot_fire          = !boot_done_reg
                                && (CW'(now_reg) >= CW'(BOOT_ANNOUNCE_DELAY_MS));
    assign last_ann_next_boot = boot_fire ? now_reg : last_ann_reg;

    // The boot announce may refresh the announce time in the same word, so
    // the refresh check measures from the updated value.
    assign ann_age     = now_reg - last_ann_next_boot;
    assign refresh_due = CW'(ann_age) >= CW'(ann_refresh_reg);

    always_comb
    begin
        mode_next       = mode_reg;
        soft_cnt_next   = soft_cnt_reg;
        hard_cnt_next   = hard_cnt_reg;
        fail_cnt_next   = fail_cnt_reg;
        probe_run_next  = probe_run_reg;
        probe_t0_next   = probe_t0_reg;
        last_check_next = last_check_reg;
        last_ann_next   = last_ann_next_boot;
        boot_done_next  = boot_done_reg || boot_fire;
        act             = ACT_NONE;
        end_probe_c     = 1'b0;
        announce_c      = boot_fire;
        resync_c        = 1'b0;
        recover         = 1'b0;
        finished        = 1'b0;

        if (probe_run_reg)
        begin
            // A running probe ends on a reply or on timeout.
            if (reply_reg || timed_out)
            begin
                end_probe_c    = 1'b1;
                probe_run_next = 1'b0;
                if (!reply_reg)
                begin
                    fail_cnt_next = fail_bumped;
                    if (fail_bumped < fail_thresh_reg)
                    begin
                        last_check_next = now_reg;
                        finished        = 1'b1;
                    end
                end
                if (!finished)
                begin
                    if (refresh_due)
                    begin
                        announce_c    = 1'b1;
                        last_ann_next = now_reg;
                    end
                    if (reply_reg)
                    begin
                        // Reply received: the link is healthy again.
                        resync_c        = (mode_reg != MODE_HEALTHY);
                        mode_next       = MODE_HEALTHY;
                        soft_cnt_next   = '0;
                        hard_cnt_next   = '0;
                        fail_cnt_next   = '0;
                        last_check_next = now_reg;
                    end
                    else
                    begin
                        // Failure threshold reached: count as link loss.
                        fail_cnt_next = '0;
                        recover       = 1'b1;
                    end
                end
            end
        end
        else if (check_due)
        begin
            last_check_next = now_reg;
            if (!link_up_reg)
            begin
                recover = 1'b1;
            end
            else if (can_start_reg)
            begin
                probe_run_next = 1'b1;
                probe_t0_next  = now_reg;
                act            = ACT_PROBE;
            end
            else
            begin
                // No gateway to probe counts as a failed probe.
                fail_cnt_next = fail_bumped;
                if (fail_bumped >= fail_thresh_reg)
                begin
                    recover = 1'b1;
                end
            end
        end

        // Escalation ladder: soft tier, hard tier, then reboot or wrap.
        if (recover)
        begin
            if (soft_cnt_reg < soft_limit_reg)
            begin
                mode_next     = MODE_SOFT;
                soft_cnt_next = soft_cnt_reg + 1'b1;
                act           = ACT_SOFT;
            end
            else if (hard_cnt_reg < hard_limit_reg)
            begin
                mode_next     = MODE_HARD;
                hard_cnt_next = hard_cnt_reg + 1'b1;
                act           = ACT_HARD;
                if (hard_ok_reg)
                begin
                    announce_c    = 1'b1;
                    last_ann_next = now_reg;
                    resync_c      = 1'b1;
                    mode_next     = MODE_HEALTHY;
                    soft_cnt_next = '0;
                    hard_cnt_next = '0;
                    fail_cnt_next = '0;
                end
            end
            else if (!auto_reboot_reg)
            begin
                soft_cnt_next = '0;
                hard_cnt_next = '0;
            end
            else
            begin
                mode_next = MODE_REBOOT;
                act       = ACT_REBOOT;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    action_t            action_reg;
    logic               end_probe_reg;
    logic               announce_reg;
    logic               resync_reg;
    wd_mode_t           state_out_reg;
    logic [COUNT_W-1:0] soft_out_reg;
    logic [COUNT_W-1:0] hard_out_reg;
    logic [COUNT_W-1:0] fail_out_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            action_reg    <= act;
            end_probe_reg <= end_probe_c;
            announce_reg  <= announce_c;
            resync_reg    <= resync_c;
            state_out_reg <= mode_next;
            soft_out_reg  <= soft_cnt_next;
            hard_out_reg  <= hard_cnt_next;
            fail_out_reg  <= fail_cnt_next;
        end
    end

    assign res.action           = action_reg;
    assign res.end_probe        = end_probe_reg;
    assign res.restart_announce = announce_reg;
    assign res.resync_time      = resync_reg;
    assign res.watchdog_state   = state_out_reg;
    assign res.soft_tries       = soft_out_reg;
    assign res.hard_tries       = hard_out_reg;
    assign res.probe_fails      = fail_out_reg;

endmodule

@@ tb/link_watchdog_escalation_top_tb.sv @@
// Self-checking testbench for link_watchdog_escalation_top: directed rows, then
// randomized phases under several register settings, all checked word by word.
// Depends on lwe_pkg and the channel interfaces in lwe_if.sv from the RTL.
`timescale 1ns / 1ps

module link_watchdog_escalation_top_tb;
    import lwe_pkg::*;

    // Longest stretch of cycles in which no word moves on either channel.
    // A correct run stays far below this: the longest sender gap and the
    // longest result stall are one long idle stretch each, plus a short pause.
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned PHASES      = 10;
    localparam int unsigned PHASE_WORDS = 130;
    localparam int unsigned SAT_WORDS   = 400;
    localparam int unsigned PRINT_CAP   = 40;

    // One event word as it is offered to the block.
    typedef struct packed {
        logic [MS_W-1:0] now_ms;
        logic            link_up;
        logic            probe_reply;
        logic            probe_can_start;
        logic            hard_reconnect_ok;
    } event_t;

    // What the watchdog decides for one event word.
    typedef struct packed {
        action_t            action;
        logic               end_probe;
        logic               restart_announce;
        logic               resync_time;
        wd_mode_t           state;
        logic [COUNT_W-1:0] soft_tries;
        logic [COUNT_W-1:0] hard_tries;
        logic [COUNT_W-1:0] probe_fails;
    } decision_t;

    // One row of the directed part; the wanted decision is used only when
    // the row carries a hand-written one.
    typedef struct packed {
        event_t    ev;
        logic      typed;
        decision_t want;
    } directed_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    lwe_in_if  events_if ();
    lwe_out_if results_if ();

    link_watchdog_escalation_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt       (events_if),
        .res       (results_if)
    );

    // Our own copy of the configuration registers.
    logic [COUNT_W-1:0] c_soft_limit;
    logic [COUNT_W-1:0] c_hard_limit;
    logic [COUNT_W-1:0] c_threshold;
    logic [MS_W-1:0]    c_healthy;
    logic [MS_W-1:0]    c_recovery;
    logic [MS_W-1:0]    c_timeout;
    logic [MS_W-1:0]    c_refresh;
    logic               c_auto_reboot;

    // Our own copy of the watchdog state.
    wd_mode_t           w_mode;
    logic [COUNT_W-1:0] w_soft;
    logic [COUNT_W-1:0] w_hard;
    logic [COUNT_W-1:0] w_fails;
    logic               w_probe_on;
    logic [MS_W-1:0]    w_probe_t0;
    logic [MS_W-1:0]    w_check_t;
    logic [MS_W-1:0]    w_announce_t;
    logic               w_boot_done;

    // Decisions accepted on the event side and not yet seen on the result side.
    decision_t     awaited_decisions[$];
    directed_row_t directed_rows[$];

    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned quiet_cycles = 0;

    // Sender and receiver pacing. A calm stretch starts no new idling.
    logic        tx_calm = 1'b0;
    int unsigned tx_words = 0;
    logic        rx_calm = 1'b0;
    int unsigned rx_cycles = 0;
    int unsigned stall_left = 0;

    // Per-phase shape of the random event stream.
    logic [MS_W-1:0] clock_ms;
    int unsigned     stride;
    int unsigned     reply_pct;
    int unsigned     can_pct;
    int unsigned     flip_pct;
    logic            link_state;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Time differences wrap at 32 bits, just like the free-running counter.
    function automatic logic [MS_W-1:0] since(input logic [MS_W-1:0] now,
                                               input logic [MS_W-1:0] then);
        return now - then;
    endfunction

    function automatic decision_t outcome(input action_t a, input logic ep,
                                          input logic ra, input logic rt,
                                          input wd_mode_t m, input logic [7:0] s,
                                          input logic [7:0] h, input logic [7:0] f);
        decision_t d;
        d.action           = a;
        d.end_probe        = ep;
        d.restart_announce = ra;
        d.resync_time      = rt;
        d.state            = m;
        d.soft_tries       = s;
        d.hard_tries       = h;
        d.probe_fails      = f;
        return d;
    endfunction

    // Works out what the watchdog orders for one event and advances our copy
    // of its state. A probe that times out below the failure threshold only
    // counts the failure and restarts the check timer; one at or above it, a
    // down link, or a failed probe start at or past the threshold all escalate.
    function automatic decision_t decide(input event_t ev);
        decision_t       d;
        logic            recover;
        logic            settled;
        logic [MS_W-1:0] interval;
        d = outcome(ACT_NONE, 1'b0, 1'b0, 1'b0, MODE_HEALTHY, 8'd0, 8'd0, 8'd0);
        recover = 1'b0;
        settled = 1'b0;

        // The boot announce looks at absolute time and fires only once.
        if (!w_boot_done && ev.now_ms >= BOOT_ANNOUNCE_DELAY_MS_DEF) begin
            w_boot_done        = 1'b1;
            d.restart_announce = 1'b1;
            w_announce_t       = ev.now_ms;
        end

        if (w_probe_on) begin
            if (ev.probe_reply || since(ev.now_ms, w_probe_t0) >= c_timeout) begin
                d.end_probe = 1'b1;
                w_probe_on  = 1'b0;
                if (!ev.probe_reply) begin
                    if (w_fails != COUNT_MAX)
                        w_fails++;
                    if (w_fails < c_threshold) begin
                        w_check_t = ev.now_ms;
                        settled   = 1'b1;
                    end
                end else begin
                    w_fails = '0;
                end
                if (!settled) begin
                    if (since(ev.now_ms, w_announce_t) >= c_refresh) begin
                        d.restart_announce = 1'b1;
                        w_announce_t       = ev.now_ms;
                    end
                    if (ev.probe_reply) begin
                        if (w_mode != MODE_HEALTHY)
                            d.resync_time = 1'b1;
                        w_mode    = MODE_HEALTHY;
                        w_soft    = '0;
                        w_hard    = '0;
                        w_fails   = '0;
                        w_check_t = ev.now_ms;
                    end else begin
                        w_fails = '0;
                        recover = 1'b1;
                    end
                end
            end
        end else begin
            interval = (w_mode != MODE_HEALTHY || w_fails != 0) ? c_recovery : c_healthy;
            if (since(ev.now_ms, w_check_t) >= interval) begin
                w_check_t = ev.now_ms;
                if (!ev.link_up) begin
                    recover = 1'b1;
                end else if (ev.probe_can_start) begin
                    w_probe_on = 1'b1;
                    w_probe_t0 = ev.now_ms;
                    d.action   = ACT_PROBE;
                end else begin
                    if (w_fails != COUNT_MAX)
                        w_fails++;
                    if (w_fails >= c_threshold)
                        recover = 1'b1;
                end
            end
        end

        if (recover) begin
            if (w_soft < c_soft_limit) begin
                w_mode   = MODE_SOFT;
                w_soft++;
                d.action = ACT_SOFT;
            end else if (w_hard < c_hard_limit) begin
                w_mode   = MODE_HARD;
                w_hard++;
                d.action = ACT_HARD;
                if (ev.hard_reconnect_ok) begin
                    d.restart_announce = 1'b1;
                    d.resync_time      = 1'b1;
                    w_announce_t       = ev.now_ms;
                    w_mode             = MODE_HEALTHY;
                    w_soft             = '0;
                    w_hard             = '0;
                    w_fails            = '0;
                end
            end else if (!c_auto_reboot) begin
                // Both tiers spent with reboot disabled: start over at the soft tier.
                w_soft = '0;
                w_hard = '0;
            end else begin
                w_mode   = MODE_REBOOT;
                d.action = ACT_REBOOT;
            end
        end

        d.state       = w_mode;
        d.soft_tries  = w_soft;
        d.hard_tries  = w_hard;
        d.probe_fails = w_fails;
        return d;
    endfunction

    // Mostly short idle stretches, now and then a long one.
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        else if (r < 90)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report($sformatf("result word %0d, %s = %0h, expected %0h",
                             results_seen, name, got, want));
    endtask

    task automatic add_row(input logic [MS_W-1:0] now, input logic l, input logic r,
                           input logic c, input logic h);
        directed_row_t row;
        row.ev    = '{now, l, r, c, h};
        row.typed = 1'b0;
        row.want  = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_row_expect(input logic [MS_W-1:0] now, input logic l,
                                  input logic r, input logic c, input logic h,
                                  input decision_t want);
        directed_row_t row;
        row.ev    = '{now, l, r, c, h};
        row.typed = 1'b1;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Offers one event word, with an optional gap in front, and returns at
    // the edge where the block takes it. Valid is left high so that a word
    // sent straight after keeps the channel busy without a bubble.
    task automatic send_word(input event_t ev);
        int unsigned gap;
        gap = 0;
        if (!tx_calm && $urandom_range(0, 99) < 35)
            gap = idle_length();
        repeat (gap) begin
            events_if.valid <= 1'b0;
            @(posedge clk);
        end
        events_if.valid             <= 1'b1;
        events_if.now_ms            <= ev.now_ms;
        events_if.link_up           <= ev.link_up;
        events_if.probe_reply       <= ev.probe_reply;
        events_if.probe_can_start   <= ev.probe_can_start;
        events_if.hard_reconnect_ok <= ev.hard_reconnect_ok;
        @(posedge clk);
        while (!events_if.ready)
            @(posedge clk);
        tx_words++;
        if (tx_words % 40 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
    endtask

    // Writes one register at the next edge and mirrors it, masked to its width.
    // The write enable is left high; the caller lowers it after the last write.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_SOFT_RETRY_LIMIT:     c_soft_limit  = data[COUNT_W-1:0];
            REG_HARD_RETRY_LIMIT:     c_hard_limit  = data[COUNT_W-1:0];
            REG_PROBE_FAIL_THRESHOLD: c_threshold   = data[COUNT_W-1:0];
            REG_HEALTHY_INTERVAL_MS:  c_healthy     = data;
            REG_RECOVERY_INTERVAL_MS: c_recovery    = data;
            REG_PROBE_TIMEOUT_MS:     c_timeout     = data;
            REG_ANNOUNCE_REFRESH_MS:  c_refresh     = data;
            REG_AUTO_REBOOT_ENABLE:   c_auto_reboot = data[0];
            default: ;
        endcase
    endtask

    // Waits until every awaited word is back, then pauses so that the block
    // is quiet before registers change or the run ends.
    task automatic settle();
        events_if.valid <= 1'b0;
        while (awaited_decisions.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Result side: checks each word taken and paces ready with random stalls.
    always @(posedge clk) begin
        if (!rst_n) begin
            results_if.ready <= 1'b0;
        end else begin
            if (results_if.valid && results_if.ready) begin
                if (awaited_decisions.size() == 0) begin
                    report($sformatf("result word %0d arrived with nothing awaited",
                                     results_seen));
                end else begin
                    decision_t want;
                    want = awaited_decisions.pop_front();
                    compare_field("action", 8'(results_if.action), 8'(want.action));
                    compare_field("end_probe", 8'(results_if.end_probe),
                                  8'(want.end_probe));
                    compare_field("restart_announce", 8'(results_if.restart_announce),
                                  8'(want.restart_announce));
                    compare_field("resync_time", 8'(results_if.resync_time),
                                  8'(want.resync_time));
                    compare_field("watchdog_state", 8'(results_if.watchdog_state),
                                  8'(want.state));
                    compare_field("soft_tries", results_if.soft_tries, want.soft_tries);
                    compare_field("hard_tries", results_if.hard_tries, want.hard_tries);
                    compare_field("probe_fails", results_if.probe_fails, want.probe_fails);
                end
                results_seen++;
            end

            rx_cycles++;
            if (rx_cycles % 50 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (stall_left > 0) begin
                results_if.ready <= 1'b0;
                stall_left--;
            end else begin
                results_if.ready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 99) < 20)
                    stall_left = idle_length();
            end
        end
    end

    // Ends a hung run: counts cycles in which no word moves on either side.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((events_if.valid && events_if.ready) || (results_if.valid && results_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        decision_t       got;
        event_t          ev;
        logic [31:0]     noise;
        logic [7:0]      s_soft;
        logic [7:0]      s_hard;
        logic [7:0]      s_thr;
        logic [31:0]     s_healthy;
        logic [31:0]     s_recovery;
        logic [31:0]     s_timeout;
        logic [31:0]     s_refresh;
        logic            s_auto;
        int unsigned     n_words;
        int unsigned     r;

        // Every input is known from time zero.
        rst_n                       = 1'b0;
        cfg_wr_en                   = 1'b0;
        cfg_index                   = '0;
        cfg_data                    = '0;
        events_if.valid             = 1'b0;
        events_if.now_ms            = '0;
        events_if.link_up           = 1'b0;
        events_if.probe_reply       = 1'b0;
        events_if.probe_can_start   = 1'b0;
        events_if.hard_reconnect_ok = 1'b0;

        // Our copy starts from the reset values.
        c_soft_limit  = SOFT_RETRY_LIMIT_RST;
        c_hard_limit  = HARD_RETRY_LIMIT_RST;
        c_threshold   = PROBE_FAIL_THRESHOLD_RST;
        c_healthy     = HEALTHY_INTERVAL_MS_RST;
        c_recovery    = RECOVERY_INTERVAL_MS_RST;
        c_timeout     = PROBE_TIMEOUT_MS_RST;
        c_refresh     = ANNOUNCE_REFRESH_MS_RST;
        c_auto_reboot = 1'b1;
        w_mode        = MODE_HEALTHY;
        w_soft        = '0;
        w_hard        = '0;
        w_fails       = '0;
        w_probe_on    = 1'b0;
        w_probe_t0    = '0;
        w_check_t     = '0;
        w_announce_t  = '0;
        w_boot_done   = 1'b0;

        // Directed part under the reset settings (healthy 10000, recovery 5000,
        // timeout 3000, threshold 3, three soft and two hard tries, reboot on).
        // First the quiet start, the boot announce exactly at its delay and a
        // probe, then a timed-out probe and a failed start below threshold.
        add_row_expect(32'd0, 1, 0, 1, 0,
                       outcome(ACT_NONE, 0, 0, 0, MODE_HEALTHY, 0, 0, 0));
        add_row_expect(32'd9999, 1, 0, 1, 0,
                       outcome(ACT_NONE, 0, 0, 0, MODE_HEALTHY, 0, 0, 0));
        add_row_expect(32'd10000, 1, 0, 1, 0,
                       outcome(ACT_PROBE, 0, 1, 0, MODE_HEALTHY, 0, 0, 0));
        add_row_expect(32'd12999, 1, 0, 1, 0,
                       outcome(ACT_NONE, 0, 0, 0, MODE_HEALTHY, 0, 0, 0));
        add_row_expect(32'd13000, 1, 0, 1, 0,
                       outcome(ACT_NONE, 1, 0, 0, MODE_HEALTHY, 0, 0, 1));
        add_row_expect(32'd18000, 1, 0, 0, 0,
                       outcome(ACT_NONE, 0, 0, 0, MODE_HEALTHY, 0, 0, 2));
        // Link down: three soft tries, then the hard tier, which succeeds on
        // its second try and brings everything back to healthy.
        add_row_expect(32'd23000, 0, 0, 1, 0,
                       outcome(ACT_SOFT, 0, 0, 0, MODE_SOFT, 1, 0, 2));
        add_row_expect(32'd28000, 0, 0, 1, 0,
                       outcome(ACT_SOFT, 0, 0, 0, MODE_SOFT, 2, 0, 2));
        add_row_expect(32'd33000, 0, 0, 1, 0,
                       outcome(ACT_SOFT, 0, 0, 0, MODE_SOFT, 3, 0, 2));
        add_row_expect(32'd38000, 0, 0, 1, 0,
                       outcome(ACT_HARD, 0, 0, 0, MODE_HARD, 3, 1, 2));
        add_row_expect(32'd43000, 0, 0, 1, 1,
                       outcome(ACT_HARD, 0, 1, 1, MODE_HEALTHY, 0, 0, 0));
        // Escalate all the way to reboot, reboot again, then recover by a
        // probe reply, which orders a time resync.
        add_row(32'd53000, 0, 0, 1, 0);
        add_row(32'd58000, 0, 0, 1, 0);
        add_row(32'd63000, 0, 0, 1, 0);
        add_row(32'd68000, 0, 0, 1, 0);
        add_row(32'd73000, 0, 0, 1, 0);
        add_row(32'd78000, 0, 0, 1, 0);
        add_row(32'd83000, 0, 0, 1, 1);
        add_row(32'd88000, 1, 0, 1, 0);
        add_row(32'd88500, 1, 1, 1, 0);
        // A probe across the wrap of the millisecond counter, the largest
        // time value, and a hard-reconnect flag that nothing looks at.
        add_row(32'hFFFF_FFF0, 1, 0, 1, 0);
        add_row(32'h0000_0100, 1, 0, 1, 1);
        add_row(32'h0000_0C00, 1, 0, 1, 0);
        add_row(32'hFFFF_FFFF, 1, 1, 0, 1);
        add_row(32'h0000_0000, 0, 1, 1, 1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].ev);
            got = decide(directed_rows[i].ev);
            awaited_decisions.push_back(directed_rows[i].typed ? directed_rows[i].want : got);
        end

        clock_ms   = 32'd100000;
        link_state = 1'b1;

        // Random phases. Each one first waits for the block to go quiet, then
        // writes all eight registers, then streams words whose time advances
        // in steps comparable to the intervals so that checks, probes,
        // timeouts and escalations keep happening.
        for (int p = 0; p < PHASES; p++) begin
            settle();

            s_soft     = $urandom_range(0, 4);
            s_hard     = $urandom_range(0, 3);
            s_thr      = $urandom_range(1, 4);
            s_healthy  = $urandom_range(0, 60);
            s_recovery = $urandom_range(0, 40);
            s_timeout  = $urandom_range(0, 30);
            s_refresh  = $urandom_range(0, 200);
            s_auto     = $urandom_range(0, 1);
            stride     = $urandom_range(1, 25);
            r          = $urandom_range(0, 2);
            reply_pct  = (r == 0) ? 15 : (r == 1) ? 50 : 85;
            can_pct    = $urandom_range(30, 100);
            flip_pct   = 8;
            n_words    = PHASE_WORDS;
            case (p)
                0: begin
                    // No tries at all and reboot off: every loss just clears counts.
                    s_soft = 8'd0;
                    s_hard = 8'd0;
                    s_auto = 1'b0;
                end
                1: begin
                    s_soft = 8'd255;
                    s_hard = 8'd255;
                    s_thr  = 8'd255;
                    s_auto = 1'b1;
                end
                2: begin
                    // Zero threshold: any failure is a link loss at once.
                    s_thr      = 8'd0;
                    s_healthy  = 32'd0;
                    s_recovery = 32'd0;
                    s_timeout  = 32'd0;
                    s_refresh  = 32'd0;
                end
                3: begin
                    s_healthy  = 32'hFFFF_FFFF;
                    s_recovery = 32'hFFFF_FFFF;
                    s_timeout  = 32'hFFFF_FFFF;
                    s_refresh  = 32'hFFFF_FFFF;
                    s_auto     = 1'b1;
                end
                4: begin
                    // A check on every word with no probe possible and no hard
                    // tier to clear it: the failure count climbs past its top
                    // and must saturate.
                    s_thr      = 8'd1;
                    s_hard     = 8'd0;
                    s_healthy  = 32'd0;
                    s_recovery = 32'd0;
                    can_pct    = 0;
                    flip_pct   = 0;
                    link_state = 1'b1;
                    n_words    = SAT_WORDS;
                end
                default: ;
            endcase

            noise = $urandom();
            write_reg(REG_SOFT_RETRY_LIMIT, {noise[31:8], s_soft});
            noise = $urandom();
            write_reg(REG_HARD_RETRY_LIMIT, {noise[31:8], s_hard});
            noise = $urandom();
            write_reg(REG_PROBE_FAIL_THRESHOLD, {noise[31:8], s_thr});
            write_reg(REG_HEALTHY_INTERVAL_MS, s_healthy);
            write_reg(REG_RECOVERY_INTERVAL_MS, s_recovery);
            write_reg(REG_PROBE_TIMEOUT_MS, s_timeout);
            write_reg(REG_ANNOUNCE_REFRESH_MS, s_refresh);
            noise = $urandom();
            write_reg(REG_AUTO_REBOOT_ENABLE, {noise[31:1], s_auto});
            cfg_wr_en <= 1'b0;

            // Sometimes start just short of the wrap of the millisecond counter.
            if ($urandom_range(0, 3) == 0)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);

            repeat (n_words) begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    clock_ms = $urandom();
                else if (r >= 12)
                    clock_ms = clock_ms + $urandom_range(0, 3 * stride);
                if ($urandom_range(0, 99) < flip_pct)
                    link_state = ~link_state;
                ev.now_ms            = clock_ms;
                ev.link_up           = link_state;
                ev.probe_reply       = ($urandom_range(0, 99) < reply_pct);
                ev.probe_can_start   = ($urandom_range(0, 99) < can_pct);
                ev.hard_reconnect_ok = $urandom_range(0, 1);
                send_word(ev);
                awaited_decisions.push_back(decide(ev));
            end
        end

        settle();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ link_watchdog_escalation_top.f @@
rtl/lwe_pkg.sv
rtl/lwe_if.sv
rtl/link_watchdog_escalation_top.sv
tb/link_watchdog_escalation_top_tb.sv
